/* rtl/core/pcc_pkg.sv */
package pcc_pkg;

  // timer and register geometry
  localparam int PCC_TIMER_WIDTH = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int BLINK_W         = 6;
  localparam int PHASE_W         = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REACT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_BEFORE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RED_AFTER  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE     = 3'd7;

  // register reset values in ticks
  localparam logic [CFG_DATA_W-1:0] RST_REACT      = 16'd15;
  localparam logic [CFG_DATA_W-1:0] RST_AMBER      = 16'd40;
  localparam logic [CFG_DATA_W-1:0] RST_RED_BEFORE = 16'd20;
  localparam logic [CFG_DATA_W-1:0] RST_STEADY     = 16'd150;
  localparam logic [BLINK_W-1:0]    RST_BLINK_CNT  = 6'd6;
  localparam logic [CFG_DATA_W-1:0] RST_BLINK_HALF = 16'd8;
  localparam logic [CFG_DATA_W-1:0] RST_RED_AFTER  = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RST_IGNORE     = 16'd50;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_REACT      = 4'd1;
  localparam logic [PHASE_W-1:0] PH_AMBER      = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RED_BEFORE = 4'd3;
  localparam logic [PHASE_W-1:0] PH_STEADY     = 4'd4;
  localparam logic [PHASE_W-1:0] PH_BLINK_OFF  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_BLINK_ON   = 4'd6;
  localparam logic [PHASE_W-1:0] PH_RED_AFTER  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_IGNORE     = 4'd8;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] react;
    logic [CFG_DATA_W-1:0] amber;
    logic [CFG_DATA_W-1:0] red_before;
    logic [CFG_DATA_W-1:0] steady;
    logic [BLINK_W-1:0]    blink_count;
    logic [CFG_DATA_W-1:0] blink_half;
    logic [CFG_DATA_W-1:0] red_after;
    logic [CFG_DATA_W-1:0] ignore_len;
  } cfg_regs_t;

  typedef struct packed {
    logic car_green;
    logic car_amber;
    logic car_red;
    logic walk_green;
    logic walk_red;
  } lamps_t;

  // lamp pattern shown during a phase
  function automatic lamps_t pcc_lamps(input logic [PHASE_W-1:0] ph);
    lamps_t l;
    l = '0;
    case (ph)
      PH_AMBER: begin
        l.car_amber = 1'b1;
        l.walk_red  = 1'b1;
      end
      PH_RED_BEFORE, PH_RED_AFTER: begin
        l.car_red  = 1'b1;
        l.walk_red = 1'b1;
      end
      PH_STEADY, PH_BLINK_ON: begin
        l.car_red    = 1'b1;
        l.walk_green = 1'b1;
      end
      PH_BLINK_OFF: begin
        l.car_red = 1'b1;
      end
      default: begin
        l.car_green = 1'b1;
        l.walk_red  = 1'b1;
      end
    endcase
    return l;
  endfunction

endpackage

/* rtl/core/pcc_if.sv */
// tick word channel
interface pcc_in_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink (input valid, input button_pressed, output ready);
endinterface

// lamp word channel
interface pcc_out_if;
  logic       valid;
  logic       ready;
  logic       car_green;
  logic       car_amber;
  logic       car_red;
  logic       walk_green;
  logic       walk_red;
  logic [3:0] phase;

  modport source (output valid, output car_green, output car_amber, output car_red,
                  output walk_green, output walk_red, output phase, input ready);
  modport sink (input valid, input car_green, input car_amber, input car_red,
                input walk_green, input walk_red, input phase, output ready);
endinterface

/* rtl/core/pcc_cfg_regs.sv */
module pcc_cfg_regs
  import pcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // decode write, unused high bits dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_REACT:      regs_nxt.react       = cfg_wdata;
        REG_AMBER:      regs_nxt.amber       = cfg_wdata;
        REG_RED_BEFORE: regs_nxt.red_before  = cfg_wdata;
        REG_STEADY:     regs_nxt.steady      = cfg_wdata;
        REG_BLINK_CNT:  regs_nxt.blink_count = cfg_wdata[BLINK_W-1:0];
        REG_BLINK_HALF: regs_nxt.blink_half  = cfg_wdata;
        REG_RED_AFTER:  regs_nxt.red_after   = cfg_wdata;
        REG_IGNORE:     regs_nxt.ignore_len  = cfg_wdata;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.react       <= RST_REACT;
      regs_r.amber       <= RST_AMBER;
      regs_r.red_before  <= RST_RED_BEFORE;
      regs_r.steady      <= RST_STEADY;
      regs_r.blink_count <= RST_BLINK_CNT;
      regs_r.blink_half  <= RST_BLINK_HALF;
      regs_r.red_after   <= RST_RED_AFTER;
      regs_r.ignore_len  <= RST_IGNORE;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

/* rtl/core/pedestrian_crossing_controller.sv */
// Pedestrian crossing controller.
// in_ch carries one word per 100 ms tick with the sampled push button level.
// out_ch returns exactly one word per tick word: the five lamps and the phase
// code shown during that tick. A press seen in idle makes that same tick the
// first tick of the first phase with a nonzero count.
// Output: the lamp word is valid the cycle after its tick word is accepted.
// Rate: one tick word per cycle unless stalled; the phase, tick and blink
// counters are updated by one compare and increment per word, and the output
// register frees in_ch.ready whenever it is empty or drained in the same cycle.
// Stall: while out_ch.ready is low with a word pending, in_ch.ready is low and
// the sequence holds; no tick is lost or counted twice.
// Configuration: cfg_we writes cfg_wdata into the register named by cfg_index;
// phase counts are read live, a zero count skips its phase, and counts above
// the timer range saturate. Write only while no tick word is outstanding.
// Reset (rst_n low, synchronous): phase idle, counters zero, registers back
// to their defaults, output word empty.
module pedestrian_crossing_controller
  import pcc_pkg::*;
#(
  parameter int TIMER_WIDTH = PCC_TIMER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pcc_in_if.sink                in_ch,
  pcc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LW = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

  cfg_regs_t regs;

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt;
  logic [BLINK_W-1:0]     blinks_r, blinks_nxt;
  logic                   out_valid_r, out_valid_nxt;
  lamps_t                 lamps_r, lamps_nxt;
  logic [PHASE_W-1:0]     out_phase_r;

  logic                   in_acc;
  logic [PHASE_W-1:0]     ph_cur, p_eff, p_after;
  logic [TIMER_WIDTH-1:0] tick_base, tick_inc;
  logic [BLINK_W-1:0]     blinks_base, blinks_inc;
  logic [TIMER_WIDTH-1:0] len_react, len_amber, len_red_before, len_steady;
  logic [TIMER_WIDTH-1:0] len_blink, len_red_after, len_ignore, len_cur;
  logic [8:1]             nz;
  logic                   phase_end;

  pcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // clamp a register count to the timer range
  function automatic logic [TIMER_WIDTH-1:0] sat_len(input logic [CFG_DATA_W-1:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    if (ext > LW'(TMAX)) return TMAX;
    return ext[TIMER_WIDTH-1:0];
  endfunction

  // first phase at or after start with a nonzero count, idle if none
  function automatic logic [PHASE_W-1:0] first_from(input logic [PHASE_W-1:0] start,
                                                    input logic [8:1] nzv);
    logic [PHASE_W-1:0] res;
    logic               found;
    res   = PH_IDLE;
    found = 1'b0;
    for (int q = 1; q <= 8; q++) begin
      if (!found && PHASE_W'(q) >= start && nzv[q]) begin
        res   = PHASE_W'(q);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // live phase lengths
  assign len_react      = sat_len(regs.react);
  assign len_amber      = sat_len(regs.amber);
  assign len_red_before = sat_len(regs.red_before);
  assign len_steady     = sat_len(regs.steady);
  assign len_blink      = (regs.blink_count == '0) ? '0 : sat_len(regs.blink_half);
  assign len_red_after  = sat_len(regs.red_after);
  assign len_ignore     = sat_len(regs.ignore_len);

  assign nz = {len_ignore != '0, len_red_after != '0, len_blink != '0, len_blink != '0,
               len_steady != '0, len_red_before != '0, len_amber != '0, len_react != '0};

  // handshake: output register parts the two sides
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // phase shown this tick, a press in idle starts the sequence
  always_comb begin
    ph_cur      = (phase_r > PH_IGNORE) ? PH_IDLE : phase_r;
    p_eff       = ph_cur;
    tick_base   = tick_r;
    blinks_base = blinks_r;
    if (ph_cur == PH_IDLE && in_ch.button_pressed) begin
      p_eff     = first_from(PH_REACT, nz);
      tick_base = '0;
      if (p_eff == PH_BLINK_OFF) blinks_base = '0;
    end
  end

  always_comb begin
    case (p_eff)
      PH_REACT:                  len_cur = len_react;
      PH_AMBER:                  len_cur = len_amber;
      PH_RED_BEFORE:             len_cur = len_red_before;
      PH_STEADY:                 len_cur = len_steady;
      PH_BLINK_OFF, PH_BLINK_ON: len_cur = len_blink;
      PH_RED_AFTER:              len_cur = len_red_after;
      PH_IGNORE:                 len_cur = len_ignore;
      default:                   len_cur = '0;
    endcase
  end

  assign tick_inc   = tick_base + 1'b1;
  assign blinks_inc = blinks_base + 1'b1;
  assign phase_end  = (tick_inc == '0) || (tick_inc >= len_cur);
  assign p_after    = first_from(p_eff + 1'b1, nz);

  // next phase, tick and blink counters
  always_comb begin
    phase_nxt  = p_eff;
    tick_nxt   = tick_base;
    blinks_nxt = blinks_base;
    if (p_eff != PH_IDLE) begin
      if (!phase_end) begin
        tick_nxt = tick_inc;
      end else if (p_eff == PH_BLINK_ON) begin
        tick_nxt   = '0;
        blinks_nxt = blinks_inc;
        if (blinks_inc != '0 && blinks_inc < regs.blink_count && nz[5]) begin
          phase_nxt = PH_BLINK_OFF;
        end else begin
          phase_nxt = first_from(PH_RED_AFTER, nz);
        end
      end else begin
        tick_nxt  = '0;
        phase_nxt = p_after;
        if (p_after == PH_BLINK_OFF) blinks_nxt = '0;
      end
    end
  end

  assign lamps_nxt     = pcc_lamps(p_eff);
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  // sequence state advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      blinks_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r  <= phase_nxt;
        tick_r   <= tick_nxt;
        blinks_r <= blinks_nxt;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lamps_r     <= lamps_nxt;
      out_phase_r <= p_eff;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.car_green  = lamps_r.car_green;
  assign out_ch.car_amber  = lamps_r.car_amber;
  assign out_ch.car_red    = lamps_r.car_red;
  assign out_ch.walk_green = lamps_r.walk_green;
  assign out_ch.walk_red   = lamps_r.walk_red;
  assign out_ch.phase      = out_phase_r;

  // idle without a press stays idle
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == PH_IDLE && !in_ch.button_pressed) |=> phase_r == PH_IDLE)
    else $error("idle left without a press");

  // sequence state frozen while no tick is taken
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(phase_r) && $stable(tick_r) && $stable(blinks_r)))
    else $error("sequence state moved without a tick word");

  // cars and walkers never both get green
  a_no_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(lamps_r.car_green && lamps_r.walk_green))
    else $error("car green and walk green together");

  // blink on follows blink off, or idle when every earlier phase is skipped
  a_blink_order: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BLINK_ON && $past(phase_r) != PH_BLINK_ON)
      |-> ($past(phase_r) == PH_BLINK_OFF || $past(phase_r) == PH_IDLE))
    else $error("blink on entered out of order");

  // in_ch.ready is high whenever the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

endmodule

/* dv/pedestrian_crossing_controller_tb.sv */
module pedestrian_crossing_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_SETTINGS = 6;
  localparam int WORDS_PER_SETTING = 100;

  typedef struct packed {
    lamps_t              lamps;
    logic [PHASE_W-1:0]  phase;
  } lamp_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pcc_in_if  in_ch ();
  pcc_out_if out_ch ();

  pedestrian_crossing_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted controller state and register copy
  logic [PHASE_W-1:0]         ph_st;
  logic [PCC_TIMER_WIDTH-1:0] tick_st;
  logic [BLINK_W-1:0]         blinks_st;
  logic [CFG_DATA_W-1:0]      tick_cfg [8];

  bit          press_queue [$];
  lamp_word_t  lamp_queue [$];
  lamp_word_t  want;
  lamp_word_t  got;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_sent;
  int unsigned lamps_checked;
  int unsigned mismatches;
  int unsigned settings_run;
  int unsigned cycle_count;

  // length of a phase under the current registers
  function automatic int unsigned phase_ticks(int unsigned p);
    case (p)
      PH_REACT:      return tick_cfg[REG_REACT];
      PH_AMBER:      return tick_cfg[REG_AMBER];
      PH_RED_BEFORE: return tick_cfg[REG_RED_BEFORE];
      PH_STEADY:     return tick_cfg[REG_STEADY];
      PH_BLINK_OFF, PH_BLINK_ON:
        return (tick_cfg[REG_BLINK_CNT] == 0) ? 0 : tick_cfg[REG_BLINK_HALF];
      PH_RED_AFTER:  return tick_cfg[REG_RED_AFTER];
      PH_IGNORE:     return tick_cfg[REG_IGNORE];
      default:       return 0;
    endcase
  endfunction

  // move to a phase, skipping zero-length ones; past ignore means idle
  function automatic void enter_phase(int unsigned p);
    int unsigned q;
    q = p;
    while (1'b1) begin
      if (q == PH_IDLE || q > PH_IGNORE) begin
        q = PH_IDLE;
        break;
      end
      if (q == PH_BLINK_OFF && phase_ticks(PH_BLINK_OFF) == 0) begin
        q = PH_RED_AFTER;
        continue;
      end
      if (phase_ticks(q) != 0) break;
      q++;
    end
    if (q == PH_BLINK_OFF) blinks_st = '0;
    ph_st   = q[PHASE_W-1:0];
    tick_st = '0;
  endfunction

  // lamps shown for one tick, then advance the sequence
  function automatic lamp_word_t next_lamps(logic btn);
    lamp_word_t         w;
    logic [PHASE_W-1:0] p;
    if (ph_st > PH_IGNORE) ph_st = PH_IDLE;
    if (ph_st == PH_IDLE && btn) enter_phase(PH_REACT);
    p = ph_st;
    w = '0;
    w.phase = p;
    case (p)
      PH_AMBER: begin
        w.lamps.car_amber = 1'b1;
        w.lamps.walk_red  = 1'b1;
      end
      PH_RED_BEFORE, PH_RED_AFTER: begin
        w.lamps.car_red  = 1'b1;
        w.lamps.walk_red = 1'b1;
      end
      PH_STEADY, PH_BLINK_ON: begin
        w.lamps.car_red    = 1'b1;
        w.lamps.walk_green = 1'b1;
      end
      PH_BLINK_OFF: begin
        w.lamps.car_red = 1'b1;
      end
      default: begin
        w.lamps.car_green = 1'b1;
        w.lamps.walk_red  = 1'b1;
      end
    endcase
    if (p != PH_IDLE) begin
      tick_st = tick_st + 1'b1;
      if (tick_st == 0 || tick_st >= phase_ticks(p)) begin
        if (p == PH_BLINK_ON) begin
          blinks_st = blinks_st + 1'b1;
          // another off/on pair while the live blink count allows it
          if (blinks_st != 0 && blinks_st < tick_cfg[REG_BLINK_CNT] &&
              phase_ticks(PH_BLINK_OFF) != 0) begin
            ph_st   = PH_BLINK_OFF;
            tick_st = '0;
          end else begin
            enter_phase(PH_RED_AFTER);
          end
        end else begin
          enter_phase(p + 1);
        end
      end
    end
    return w;
  endfunction

  // tick word driver, acceptance feeds the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lamp_queue.push_back(next_lamps(in_ch.button_pressed));
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (press_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid          <= 1'b1;
          in_ch.button_pressed <= press_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // lamp word monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        got.lamps.car_green  = out_ch.car_green;
        got.lamps.car_amber  = out_ch.car_amber;
        got.lamps.car_red    = out_ch.car_red;
        got.lamps.walk_green = out_ch.walk_green;
        got.lamps.walk_red   = out_ch.walk_red;
        got.phase            = out_ch.phase;
        if (lamp_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected lamp word %b phase %0d", got.lamps, got.phase);
        end else begin
          want = lamp_queue.pop_front();
          lamps_checked++;
          if (got.lamps.car_green !== want.lamps.car_green ||
              got.lamps.car_amber !== want.lamps.car_amber ||
              got.lamps.car_red !== want.lamps.car_red ||
              got.lamps.walk_green !== want.lamps.walk_green ||
              got.lamps.walk_red !== want.lamps.walk_red ||
              got.phase !== want.phase) begin
            mismatches++;
            if (mismatches <= 10)
              $display("lamp word %0d: expected lamps %b phase %0d, got lamps %b phase %0d",
                       lamps_checked, want.lamps, want.phase, got.lamps, got.phase);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lamp words still expected",
               cycle_count, lamp_queue.size());
      $display("simulation failed");
      $finish;
    end
  end

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    tick_cfg[idx] = (idx == REG_BLINK_CNT) ? {{(CFG_DATA_W-BLINK_W){1'b0}}, val[BLINK_W-1:0]} : val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every tick word has its lamp word back
  task automatic wait_drained();
    do @(negedge clk);
    while (press_queue.size() != 0 || in_ch.valid || lamp_queue.size() != 0);
  endtask

  task automatic queue_presses(input bit btns []);
    foreach (btns[i]) press_queue.push_back(btns[i]);
  endtask

  // mostly short phases, now and then a skipped or a maximal one
  function automatic logic [CFG_DATA_W-1:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 82) return CFG_DATA_W'($urandom_range(4, 1));
    if (r < 97) return CFG_DATA_W'($urandom_range(12, 5));
    return '1;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] vals [8];
    int unsigned press_pct;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.button_pressed = 1'b0;
    out_ch.ready         = 1'b0;
    send_idle_pct        = 28;
    recv_stall_pct       = 67;
    words_sent           = 0;
    lamps_checked        = 0;
    mismatches           = 0;
    settings_run         = 0;
    cycle_count          = 0;

    // predictor reset
    tick_cfg[REG_REACT]      = RST_REACT;
    tick_cfg[REG_AMBER]      = RST_AMBER;
    tick_cfg[REG_RED_BEFORE] = RST_RED_BEFORE;
    tick_cfg[REG_STEADY]     = RST_STEADY;
    tick_cfg[REG_BLINK_CNT]  = {{(CFG_DATA_W-BLINK_W){1'b0}}, RST_BLINK_CNT};
    tick_cfg[REG_BLINK_HALF] = RST_BLINK_HALF;
    tick_cfg[REG_RED_AFTER]  = RST_RED_AFTER;
    tick_cfg[REG_IGNORE]     = RST_IGNORE;
    ph_st     = PH_IDLE;
    tick_st   = '0;
    blinks_st = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: press in idle starts react, presses while busy are dropped
    queue_presses('{1'b0, 1'b1, 1'b1, 1'b0});
    wait_drained();
    repeat (2) @(negedge clk);

    // lowering react below the ticks already spent ends it, short full cycle
    write_reg(REG_REACT, 16'd2);
    write_reg(REG_AMBER, 16'd1);
    write_reg(REG_RED_BEFORE, 16'd1);
    write_reg(REG_STEADY, 16'd1);
    write_reg(REG_BLINK_CNT, 16'd2);
    write_reg(REG_BLINK_HALF, 16'd1);
    write_reg(REG_RED_AFTER, 16'd1);
    write_reg(REG_IGNORE, 16'd1);
    queue_presses('{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                    1'b0, 1'b0});
    wait_drained();
    repeat (2) @(negedge clk);

    // all counts zero: a press leaves the block in idle
    for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), '0);
    queue_presses('{1'b1, 1'b0});
    wait_drained();
    repeat (2) @(negedge clk);

    // zero blink count skips blinking; maximal ignore period
    write_reg(REG_STEADY, 16'd1);
    write_reg(REG_BLINK_HALF, 16'd5);
    write_reg(REG_IGNORE, 16'hFFFF);
    queue_presses('{1'b1, 1'b0, 1'b1, 1'b0});
    wait_drained();
    repeat (2) @(negedge clk);

    // ignore cut short live, then zero blink half skips blinking
    write_reg(REG_IGNORE, 16'd1);
    write_reg(REG_BLINK_CNT, 16'd63);
    write_reg(REG_BLINK_HALF, 16'd0);
    queue_presses('{1'b0, 1'b1, 1'b0, 1'b0});
    wait_drained();
    repeat (2) @(negedge clk);

    // random settings, written mid-sequence as often as not
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      if (s == 2) begin
        send_idle_pct  = 67;
        recv_stall_pct = 28;
      end else if (s == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      vals[REG_REACT]      = pick_ticks();
      vals[REG_AMBER]      = pick_ticks();
      vals[REG_RED_BEFORE] = pick_ticks();
      vals[REG_STEADY]     = pick_ticks();
      vals[REG_BLINK_HALF] = pick_ticks();
      vals[REG_RED_AFTER]  = pick_ticks();
      vals[REG_IGNORE]     = pick_ticks();
      case ($urandom_range(9))
        0:       vals[REG_BLINK_CNT] = '0;
        1:       vals[REG_BLINK_CNT] = 16'd63;
        default: vals[REG_BLINK_CNT] = CFG_DATA_W'($urandom_range(4, 1));
      endcase
      // a maximal count would stall the whole setting, keep it rare
      if (s == RANDOM_SETTINGS - 1) vals[REG_RED_BEFORE] = 16'hFFFF;
      for (int i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), vals[i]);
      press_pct = $urandom_range(40, 5);
      for (int n = 0; n < WORDS_PER_SETTING; n++)
        press_queue.push_back($urandom_range(99) < press_pct);
      settings_run++;
      wait_drained();
      repeat (2) @(negedge clk);
    end

    repeat (4) @(posedge clk);
    $display("sent %0d tick words under %0d random register settings plus directed cases",
             words_sent, settings_run);
    $display("checked %0d lamp words, %0d mismatches", lamps_checked, mismatches);
    if (mismatches == 0 && lamp_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pcc_pkg.sv
rtl/core/pcc_if.sv
rtl/core/pcc_cfg_regs.sv
rtl/core/pedestrian_crossing_controller.sv
dv/pedestrian_crossing_controller_tb.sv
